/* hdl/lcd_serial_busy_poll_framer_assert.svh */
// assertion macros shared by the lcd serial framer modules
`ifndef LCD_SERIAL_BUSY_POLL_FRAMER_ASSERT_SVH
`define LCD_SERIAL_BUSY_POLL_FRAMER_ASSERT_SVH

// property checked on every clock edge outside reset
`define LCDSF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every clock edge, reset included
`define LCDSF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/lcdsf_pkg.sv */
// types and constants of the lcd serial busy poll framer
package lcdsf_pkg;

   // request and reply codes
   localparam logic [1:0] CMD_WR_CMD  = 2'd0;
   localparam logic [1:0] CMD_WR_DATA = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;
   localparam logic [1:0] CMD_REPLY   = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT = 2'd2;

   // sync bytes
   localparam logic [7:0] SYNC_STATUS = 8'hFC;
   localparam logic [7:0] SYNC_CMD    = 8'hF8;
   localparam logic [7:0] SYNC_DATA   = 8'hFA;
   localparam logic [7:0] SYNC_READ   = 8'hFE;

   localparam int         BUSY_BIT    = 7;
   localparam int         LIMIT_W     = 20;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd100001;
   localparam logic [LIMIT_W-1:0] COUNT_MAX   = 20'hFFFFF;

   // most result words one input word can cause
   localparam int         MAX_RESULTS = 3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] value;
      logic [7:0] reply_first;
      logic [7:0] reply_second;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx_byte;
      logic [7:0] read_value;
      logic       select_high;
      logic       last;
   } rsp_type;

   // group of result words handed from the core to the queue
   typedef struct packed {
      logic [1:0]                   count;
      rsp_type [MAX_RESULTS-1:0]    word;
   } push_type;

endpackage

/* hdl/lcdsf_queue.sv */
// result queue: takes up to three words per cycle, drains one per cycle while rsp_ready is high
`include "lcd_serial_busy_poll_framer_assert.svh"

module lcdsf_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  lcdsf_pkg::push_type push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lcdsf_pkg::rsp_type  rsp_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 2;

   lcdsf_pkg::rsp_type word_ff [DEPTH];
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                 input logic [1:0] k);
      logic [PTR_W+1:0] s;
      s = {2'b00, p} + {{PTR_W{1'b0}}, k};
      if (s >= (PTR_W+2)'(DEPTH)) s = s - (PTR_W+2)'(DEPTH);
      return s[PTR_W-1:0];
   endfunction

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = word_ff[rd_ptr_ff];

   // space for a full group once this cycle's pop is counted
   assign room = ({2'b00, count_ff} <=
                  (SUM_W'(DEPTH - lcdsf_pkg::MAX_RESULTS) + SUM_W'(pop)));

   always_comb begin
      rd_ptr_in = pop ? wrap_add(rd_ptr_ff, 2'd1) : rd_ptr_ff;
      wr_ptr_in = wrap_add(wr_ptr_ff, push.count);
      count_in  = CNT_W'({2'b00, count_ff} + SUM_W'(push.count) - SUM_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < DEPTH; e++) begin
         for (int k = 0; k < lcdsf_pkg::MAX_RESULTS; k++) begin
            if ((2'(k) < push.count) && (wrap_add(wr_ptr_ff, 2'(k)) == PTR_W'(e))) begin
               word_ff[e] <= push.word[k];
            end
         end
      end
   end

   `LCDSF_ASSERT(a_no_overflow, (push.count != 2'd0) |-> ({2'b00, count_ff} + SUM_W'(push.count) - SUM_W'(pop) <= SUM_W'(DEPTH)), "result queue overflow")
   `LCDSF_ASSERT_ALWAYS(a_empty_after_reset, $past(reset) |-> (count_ff == '0), "queue not empty after reset")

endmodule

/* hdl/lcdsf_core.sv */
// framer core: busy poll phase state and result words for one input word
`include "lcd_serial_busy_poll_framer_assert.svh"

module lcdsf_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  lcdsf_pkg::req_type           item,
   input  logic [lcdsf_pkg::LIMIT_W-1:0] poll_limit,
   output lcdsf_pkg::push_type          push
);

   typedef enum logic [1:0] {PH_IDLE, PH_STATUS, PH_READ} phase_type;

   phase_type                     phase_ff, phase_in;
   logic [1:0]                    op_ff, op_in;
   logic [7:0]                    byte_ff, byte_in;
   logic [lcdsf_pkg::LIMIT_W-1:0] count_ff, count_in, count_inc;
   logic [7:0]                    joined;
   logic                          sel;
   logic                          is_idle;

   function automatic lcdsf_pkg::rsp_type mk(input logic [1:0] kind,
                                            input logic [7:0] tx,
                                            input logic [7:0] rd,
                                            input logic       s);
      lcdsf_pkg::rsp_type r;
      r.kind        = kind;
      r.tx_byte     = tx;
      r.read_value  = rd;
      r.select_high = s;
      r.last        = 1'b0;
      return r;
   endfunction

   assign joined    = {item.reply_first[7:4], item.reply_second[3:0]};
   assign sel       = (op_ff != lcdsf_pkg::CMD_READ);
   assign is_idle   = (phase_ff != PH_STATUS) && (phase_ff != PH_READ);
   assign count_inc = (count_ff < lcdsf_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      byte_in  = byte_ff;
      count_in = count_ff;
      push     = '0;
      if (take) begin
         if (item.cmd != lcdsf_pkg::CMD_REPLY) begin
            if (is_idle) begin
               op_in         = item.cmd;
               byte_in       = item.value;
               count_in      = '0;
               phase_in      = PH_STATUS;
               push.word[0]  = mk(lcdsf_pkg::KIND_TX, lcdsf_pkg::SYNC_STATUS, 8'h00,
                                  item.cmd != lcdsf_pkg::CMD_READ);
               push.count    = 2'd1;
            end
         end else begin
            case (phase_ff)
               PH_STATUS: begin
                  if (joined[lcdsf_pkg::BUSY_BIT]) begin
                     count_in     = count_inc;
                     push.word[0] = mk(lcdsf_pkg::KIND_TX, lcdsf_pkg::SYNC_STATUS, 8'h00, sel);
                     push.count   = 2'd1;
                     if (count_inc >= poll_limit) begin
                        push.word[1] = mk(lcdsf_pkg::KIND_TIMEOUT, 8'h00, 8'h00, sel);
                        push.count   = 2'd2;
                        phase_in     = PH_IDLE;
                     end
                  end else if (op_ff == lcdsf_pkg::CMD_READ) begin
                     push.word[0] = mk(lcdsf_pkg::KIND_TX, lcdsf_pkg::SYNC_READ, 8'h00, sel);
                     push.count   = 2'd1;
                     phase_in     = PH_READ;
                  end else begin
                     push.word[0] = mk(lcdsf_pkg::KIND_TX,
                                       (op_ff == lcdsf_pkg::CMD_WR_DATA) ?
                                       lcdsf_pkg::SYNC_DATA : lcdsf_pkg::SYNC_CMD,
                                       8'h00, sel);
                     push.word[1] = mk(lcdsf_pkg::KIND_TX, {byte_ff[7:4], 4'h0}, 8'h00, sel);
                     push.word[2] = mk(lcdsf_pkg::KIND_TX, {byte_ff[3:0], 4'h0}, 8'h00, sel);
                     push.count   = 2'd3;
                     phase_in     = PH_IDLE;
                  end
               end
               PH_READ: begin
                  push.word[0] = mk(lcdsf_pkg::KIND_READ, 8'h00, joined, sel);
                  push.count   = 2'd1;
                  phase_in     = PH_IDLE;
               end
               default: ;
            endcase
         end
      end
      // mark the final word of the group
      case (push.count)
         2'd1:    push.word[0].last = 1'b1;
         2'd2:    push.word[1].last = 1'b1;
         2'd3:    push.word[2].last = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= '0;
         byte_ff  <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         byte_ff  <= byte_in;
         count_ff <= count_in;
      end
   end

   `LCDSF_ASSERT(a_busy_req_silent, (take && (item.cmd != lcdsf_pkg::CMD_REPLY) && !is_idle) |-> (push.count == 2'd0), "request during busy poll produced output")
   `LCDSF_ASSERT(a_idle_after_group, (push.count == 2'd3) |=> (phase_ff == PH_IDLE), "write frame did not return to idle")

endmodule

/* hdl/lcd_serial_busy_poll_framer.sv */
// top level of the lcd serial busy poll framer
//
//  channel | ports                      | word     | direction
//  --------+----------------------------+----------+----------
//  request | req_valid req_ready req_data | req_type | in
//  result  | rsp_valid rsp_ready rsp_data | rsp_type | out
//  config  | csr_we csr_wdata           | poll_limit | in
//
// one request word is taken per cycle while each word yields at most one result and rsp_ready
// stays high; a word that yields n results (up to three) pushes them into the queue as one group
// a request passes the input register, then the queue, before its first result appears
// the result queue of QUEUE_DEPTH words sets how far requests run ahead of a stalled output
// reset clears phase, pending request, poll count and queue; poll_limit returns to 100001
// a stall on rsp_ready fills the queue, then the input register, then drops req_ready
`include "lcd_serial_busy_poll_framer_assert.svh"

module lcd_serial_busy_poll_framer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lcdsf_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lcdsf_pkg::rsp_type            rsp_data,
   input  logic                          csr_we,
   input  logic [lcdsf_pkg::LIMIT_W-1:0] csr_wdata
);

   // input register
   logic               in_vld_ff, in_vld_in;
   lcdsf_pkg::req_type in_ff;

   // busy poll limit register
   logic [lcdsf_pkg::LIMIT_W-1:0] limit_ff;

   logic                room;
   logic                core_take;
   lcdsf_pkg::push_type push;

   // the core consumes the held word only when the queue can take a full group
   assign core_take = in_vld_ff && room;
   assign req_ready = !in_vld_ff || core_take;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !core_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         limit_ff  <= lcdsf_pkg::LIMIT_RESET;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_we) limit_ff <= csr_wdata;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_ff <= req_data;
   end

   lcdsf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (core_take),
      .item       (in_ff),
      .poll_limit (limit_ff),
      .push       (push)
   );

   lcdsf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `LCDSF_ASSERT(a_accept_loads, (req_valid && req_ready) |=> in_vld_ff, "accepted word not held")
   `LCDSF_ASSERT(a_push_needs_take, (push.count != 2'd0) |-> core_take, "results without a consumed word")

endmodule

/* bench/lcd_serial_busy_poll_framer_checker.sv */
// result predictor and comparator for the lcd serial busy poll framer
`timescale 1ns / 1ps

module lcd_serial_busy_poll_framer_checker
   import lcdsf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata,
   output int                 due_count,
   output logic               link_idle,
   output int                 fail_count
);

   typedef enum logic [1:0] {LINK_IDLE, LINK_STATUS, LINK_READ} link_phase_type;

   link_phase_type     link_phase;
   logic [1:0]         held_op;
   logic [7:0]         held_byte;
   logic [LIMIT_W-1:0] busy_polls;
   logic [LIMIT_W-1:0] poll_limit;
   rsp_type            frames_due [$];

   function automatic rsp_type frame(input logic [1:0] kind, input logic [7:0] tx_byte,
                                     input logic [7:0] read_value, input logic select_high);
      rsp_type f;
      f.kind        = kind;
      f.tx_byte     = tx_byte;
      f.read_value  = read_value;
      f.select_high = select_high;
      f.last        = 1'b0;
      return f;
   endfunction

   task automatic predict_frames(input req_type w);
      rsp_type    burst [MAX_RESULTS];
      int         n;
      logic [7:0] joined;
      logic       sel;
      n      = 0;
      joined = (w.reply_first & 8'hF0) | (w.reply_second & 8'h0F);
      sel    = (held_op != CMD_READ);
      if (w.cmd != CMD_REPLY) begin
         // a new request only starts from idle
         if (link_phase == LINK_IDLE) begin
            held_op    = w.cmd;
            held_byte  = w.value;
            busy_polls = '0;
            link_phase = LINK_STATUS;
            burst[n]   = frame(KIND_TX, SYNC_STATUS, 8'h00, w.cmd != CMD_READ);
            n++;
         end
      end else if (link_phase == LINK_READ) begin
         burst[n]   = frame(KIND_READ, 8'h00, joined, sel);
         n++;
         link_phase = LINK_IDLE;
      end else if (link_phase == LINK_STATUS) begin
         if (joined[BUSY_BIT]) begin
            if (busy_polls != COUNT_MAX) busy_polls++;
            burst[n] = frame(KIND_TX, SYNC_STATUS, 8'h00, sel);
            n++;
            // a limit of zero behaves like one
            if (busy_polls >= poll_limit) begin
               burst[n]   = frame(KIND_TIMEOUT, 8'h00, 8'h00, sel);
               n++;
               link_phase = LINK_IDLE;
            end
         end else if (held_op == CMD_READ) begin
            burst[n]   = frame(KIND_TX, SYNC_READ, 8'h00, sel);
            n++;
            link_phase = LINK_READ;
         end else begin
            burst[0]   = frame(KIND_TX, (held_op == CMD_WR_DATA) ? SYNC_DATA : SYNC_CMD,
                               8'h00, sel);
            burst[1]   = frame(KIND_TX, held_byte & 8'hF0, 8'h00, sel);
            burst[2]   = frame(KIND_TX, {held_byte[3:0], 4'h0}, 8'h00, sel);
            n          = 3;
            link_phase = LINK_IDLE;
         end
      end
      if (n > 0) burst[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) frames_due.push_back(burst[i]);
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_frame(input rsp_type got);
      rsp_type want;
      if (frames_due.size() == 0) begin
         $error("result word with nothing due: kind %0d tx_byte %0h read_value %0h",
                got.kind, got.tx_byte, got.read_value);
         fail_count++;
      end else begin
         want = frames_due.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("tx_byte", want.tx_byte, got.tx_byte);
         compare_field("read_value", want.read_value, got.read_value);
         compare_field("select_high", want.select_high, got.select_high);
         compare_field("last", want.last, got.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         link_phase = LINK_IDLE;
         held_op    = '0;
         held_byte  = '0;
         busy_polls = '0;
         poll_limit = LIMIT_RESET;
         frames_due.delete();
      end else begin
         if (csr_we) poll_limit = csr_wdata;
         if (req_valid && req_ready) predict_frames(req_data);
         if (rsp_valid && rsp_ready) check_frame(rsp_data);
      end
      due_count <= frames_due.size();
      link_idle <= (link_phase == LINK_IDLE);
   end

endmodule

/* bench/lcd_serial_busy_poll_framer_tb.sv */
// top of the lcd serial busy poll framer bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module lcd_serial_busy_poll_framer_tb;
   import lcdsf_pkg::*;

   // cycles to let the input register and result queue empty out
   localparam int SETTLE_CYCLES = 12;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_we    = 1'b0;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   int                 due_count;
   int                 fail_count;
   logic               link_idle;

   // stimulus side bookkeeping
   logic [LIMIT_W-1:0] cur_limit   = LIMIT_RESET;
   int                 words_sent  = 0;
   bit                 steady      = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lcd_serial_busy_poll_framer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   lcd_serial_busy_poll_framer_checker frame_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .due_count  (due_count),
      .link_idle  (link_idle),
      .fail_count (fail_count)
   );

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type word_of(input logic [1:0] cmd, input logic [7:0] value,
                                       input logic [7:0] first, input logic [7:0] second);
      req_type w;
      w.cmd          = cmd;
      w.value        = value;
      w.reply_first  = first;
      w.reply_second = second;
      return w;
   endfunction

   // panel replies with random content, busy bit forced set or clear
   function automatic req_type busy_reply();
      return word_of(CMD_REPLY, 8'($urandom), 8'($urandom) | 8'h80, 8'($urandom));
   endfunction

   function automatic req_type ready_reply();
      return word_of(CMD_REPLY, 8'($urandom), 8'($urandom) & 8'h7F, 8'($urandom));
   endfunction

   // hold the word until taken, then maybe leave a gap
   task automatic put(input req_type w);
      int gap;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every predicted word is out
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
   endtask

   // finish any request left open, then let the pipeline go quiet
   task automatic settle();
      drain();
      while (!link_idle) begin
         put(word_of(CMD_REPLY, 8'($urandom), 8'h00, 8'h00));
         drain();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] limit);
      csr_we    <= 1'b1;
      csr_wdata <= limit;
      cur_limit  = limit;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // request, busy polls, then the ready reply and, for a read, the read reply, unless cut short or timed out
   task automatic transaction(input logic [1:0] op, input int polls, input bit cut);
      int tolerated;
      int n;
      tolerated = (cur_limit == 0) ? 1 : int'(cur_limit);
      put(word_of(op, 8'($urandom), 8'($urandom), 8'($urandom)));
      n = 1;
      for (int i = 0; i < polls && i < tolerated; i++) begin
         put(busy_reply());
         n++;
      end
      if (!cut && polls < tolerated) begin
         put(ready_reply());
         n++;
         if (op == CMD_READ) begin
            put(word_of(CMD_REPLY, 8'($urandom), 8'($urandom), 8'($urandom)));
            n++;
         end
      end
      words_sent += n;
   endtask

   task automatic random_traffic(input int quota);
      int         start;
      int         roll;
      int         polls;
      int         tolerated;
      logic [1:0] op;
      start = words_sent;
      while (words_sent - start < quota) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            // stray word, often ignored, not counted
            put(word_of(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
         end else begin
            op        = 2'($urandom_range(0, 2));
            tolerated = (cur_limit == 0) ? 1 : int'(cur_limit);
            if (tolerated <= 8 && $urandom_range(0, 3) == 0)
               polls = tolerated - $urandom_range(0, 1);
            else if ($urandom_range(0, 99) < 60)
               polls = 0;
            else
               polls = $urandom_range(1, 4);
            // a few requests are abandoned mid poll
            transaction(op, polls, roll < 15);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // write command, all zero byte, ready at once
      put(word_of(CMD_WR_CMD, 8'h00, 8'h00, 8'h00));
      put(word_of(CMD_REPLY, 8'h00, 8'h00, 8'h00));
      // write data, all ones byte, one busy poll first
      put(word_of(CMD_WR_DATA, 8'hFF, 8'hFF, 8'hFF));
      put(word_of(CMD_REPLY, 8'hFF, 8'hFF, 8'hFF));
      put(word_of(CMD_REPLY, 8'h00, 8'h7F, 8'hF0));
      // read, request byte unused, nibbles joined to all ones
      put(word_of(CMD_READ, 8'hA5, 8'h5A, 8'hC3));
      put(word_of(CMD_REPLY, 8'h3C, 8'h0F, 8'hF0));
      put(word_of(CMD_REPLY, 8'h00, 8'hF0, 8'h0F));
      // reply with no request open
      put(word_of(CMD_REPLY, 8'h81, 8'hFF, 8'hFF));
      // requests arriving while one is open get dropped
      put(word_of(CMD_WR_CMD, 8'h5A, 8'h00, 8'h00));
      put(word_of(CMD_READ, 8'hFF, 8'hFF, 8'hFF));
      put(word_of(CMD_WR_DATA, 8'h33, 8'h00, 8'h00));
      put(word_of(CMD_REPLY, 8'hFF, 8'h00, 8'hFF));
      // busy bit alone, then just below it, on a read
      put(word_of(CMD_READ, 8'h00, 8'h00, 8'h00));
      put(word_of(CMD_REPLY, 8'h00, 8'h80, 8'h00));
      put(word_of(CMD_REPLY, 8'h00, 8'h70, 8'h8F));
      put(word_of(CMD_REPLY, 8'h00, 8'hA0, 8'h05));
      settle();

      // read timing out on the first busy reply returns zero
      write_limit(20'd1);
      put(word_of(CMD_READ, 8'h00, 8'h00, 8'h00));
      put(word_of(CMD_REPLY, 8'h00, 8'h80, 8'h00));
      settle();

      // zero limit acts as one, on a write
      write_limit('0);
      put(word_of(CMD_WR_DATA, 8'hC3, 8'h00, 8'h00));
      put(word_of(CMD_REPLY, 8'h00, 8'hFF, 8'h00));
      settle();

      // random phases across several limits, the widest one without gaps
      write_limit(20'd2);
      random_traffic(80);
      settle();
      write_limit(COUNT_MAX);
      steady = 1'b1;
      random_traffic(80);
      steady = 1'b0;
      settle();
      write_limit('0);
      random_traffic(80);
      settle();
      write_limit(20'd1);
      random_traffic(80);
      settle();
      write_limit(LIMIT_W'($urandom_range(3, 6)));
      random_traffic(80);
      settle();

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // result side: bursts of ready broken by stalls, some long clean runs
   initial begin
      int run;
      int stall;
      forever begin
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* lcd_serial_busy_poll_framer.f */
+incdir+hdl
hdl/lcdsf_pkg.sv
hdl/lcdsf_queue.sv
hdl/lcdsf_core.sv
hdl/lcd_serial_busy_poll_framer.sv
bench/lcd_serial_busy_poll_framer_checker.sv
bench/lcd_serial_busy_poll_framer_tb.sv
